// ===== rtl/stng_pkg.sv =====
// shared types, constants and attenuation table for the square tone and noise generator
package stng_pkg;

    localparam int NUM_TONES = 3;
    localparam int TONE_W  = 10;
    localparam int VOL_W   = 4;
    localparam int NCTL_W  = 3;
    localparam int SHIFT_W = 16;
    localparam int AMP_W   = 15;
    localparam int SAMPLE_W = 16;
    localparam int MIX_W   = 18;

    localparam logic [SHIFT_W-1:0] NOISE_SEED  = 16'h8000;
    localparam logic [VOL_W-1:0]   VOL_SILENT  = 4'hF;
    localparam logic [TONE_W-1:0]  NOISE_DIV0  = 10'h010;
    localparam logic [TONE_W-1:0]  NOISE_DIV1  = 10'h020;
    localparam logic [TONE_W-1:0]  NOISE_DIV2  = 10'h040;
    localparam logic [1:0]         CH_NOISE    = 2'd3;

    typedef enum logic [1:0] {
        RATE_DIV16   = 2'd0,
        RATE_DIV32   = 2'd1,
        RATE_DIV64   = 2'd2,
        RATE_TONE2   = 2'd3
    } noise_rate_t;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_TICK  = 1'b1
    } action_t;

    function automatic logic [AMP_W-1:0] vol_amp(input logic [VOL_W-1:0] vol);
        logic [AMP_W-1:0] amp;
        unique case (vol)
            4'd0:    amp = 15'd32767;
            4'd1:    amp = 15'd26028;
            4'd2:    amp = 15'd20675;
            4'd3:    amp = 15'd16422;
            4'd4:    amp = 15'd13045;
            4'd5:    amp = 15'd10362;
            4'd6:    amp = 15'd8231;
            4'd7:    amp = 15'd6568;
            4'd8:    amp = 15'd5193;
            4'd9:    amp = 15'd4125;
            4'd10:   amp = 15'd3277;
            4'd11:   amp = 15'd2603;
            4'd12:   amp = 15'd2067;
            4'd13:   amp = 15'd1642;
            4'd14:   amp = 15'd1304;
            default: amp = 15'd0;
        endcase
        return amp;
    endfunction

endpackage

// ===== rtl/stng_tone.sv =====
// one square tone channel: down counter and output level
module stng_tone
    import stng_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [TONE_W-1:0] period,
    output logic              level_next
);

    logic [TONE_W-1:0] count_reg;
    logic [TONE_W-1:0] count_next;
    logic              level_reg;

    always_comb
    begin
        count_next = count_reg;
        level_next = level_reg;
        if (step)
        begin
            if (period <= TONE_W'(1))
            begin
                level_next = 1'b1;
            end
            else if (count_reg == '0)
            begin
                count_next = period - TONE_W'(1);
                level_next = ~level_reg;
            end
            else
            begin
                count_next = count_reg - TONE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            level_reg <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

endmodule

// ===== rtl/square_tone_noise_sound_generator.sv =====
// top level: bus write decode, noise channel, mixer and stream handshakes
//
// Three square tone channels, one noise channel and a mono mixer. Each input
// transaction is either a bus write byte (tuser low) or a tick (tuser high).
// An item passes through the input register and, for a tick, then through the
// output register; a new item is taken every cycle as long as the output side
// keeps up, so throughput is one item per clock. A tick's sample is computed
// from the input register and held in the output register. Writes give no
// output transaction. The limit is the single output register: while it holds
// a sample that is not taken, a waiting tick stalls the input side.
module square_tone_noise_sound_generator
    import stng_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // write_byte
    input  logic                s_axis_tuser,   // action
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata    // sample_out
);

    logic        in_valid_reg;
    logic        in_action_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;

    logic [TONE_W-1:0]  period_reg  [NUM_TONES];
    logic [TONE_W-1:0]  period_next [NUM_TONES];
    logic [VOL_W-1:0]   volume_reg  [NUM_TONES+1];
    logic [VOL_W-1:0]   volume_next [NUM_TONES+1];
    logic [NCTL_W-1:0]  nctl_reg, nctl_next;
    logic [TONE_W-1:0]  ncount_reg, ncount_next;
    logic               nflip_reg, nflip_next;
    logic [SHIFT_W-1:0] nshift_reg, nshift_next;
    logic [1:0]         latch_ch_reg, latch_ch_next;
    logic               latch_vol_reg, latch_vol_next;

    logic               out_free;
    logic               fire;
    logic               tick;
    logic               wr;
    logic [1:0]         wr_ch;
    logic               wr_vol;
    logic [TONE_W-1:0]  nreload;
    logic               nfb;
    logic [NUM_TONES-1:0] tone_level;
    logic signed [MIX_W-1:0] mix;
    logic signed [MIX_W-1:0] mix_adj;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && (in_action_reg == ACT_WRITE || out_free);
    assign tick          = fire && in_action_reg == ACT_TICK;
    assign wr            = fire && in_action_reg == ACT_WRITE;
    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign wr_ch  = in_byte_reg[7] ? in_byte_reg[6:5] : latch_ch_reg;
    assign wr_vol = in_byte_reg[7] ? in_byte_reg[4]   : latch_vol_reg;

    genvar g;
    generate
        for (g = 0; g < NUM_TONES; g++)
        begin : g_tone
            stng_tone u_tone (
                .clk        (clk),
                .rst_n      (rst_n),
                .step       (tick),
                .period     (period_reg[g]),
                .level_next (tone_level[g])
            );
        end
    endgenerate

    // register writes
    always_comb
    begin
        latch_ch_next  = latch_ch_reg;
        latch_vol_next = latch_vol_reg;
        nctl_next      = nctl_reg;
        for (int i = 0; i < NUM_TONES; i++)
        begin
            period_next[i] = period_reg[i];
        end
        for (int i = 0; i <= NUM_TONES; i++)
        begin
            volume_next[i] = volume_reg[i];
        end
        if (wr)
        begin
            latch_ch_next  = wr_ch;
            latch_vol_next = wr_vol;
            if (wr_vol)
            begin
                for (int i = 0; i <= NUM_TONES; i++)
                begin
                    if (wr_ch == 2'(i))
                    begin
                        volume_next[i] = in_byte_reg[3:0];
                    end
                end
            end
            else if (wr_ch == CH_NOISE)
            begin
                nctl_next = in_byte_reg[2:0];
            end
            else
            begin
                for (int i = 0; i < NUM_TONES; i++)
                begin
                    if (wr_ch == 2'(i))
                    begin
                        if (in_byte_reg[7])
                        begin
                            period_next[i] = {period_reg[i][TONE_W-1:4], in_byte_reg[3:0]};
                        end
                        else
                        begin
                            period_next[i] = {in_byte_reg[5:0], period_reg[i][3:0]};
                        end
                    end
                end
            end
        end
    end

    // noise channel
    always_comb
    begin
        case (noise_rate_t'(nctl_reg[1:0]))
            RATE_DIV16: nreload = NOISE_DIV0;
            RATE_DIV32: nreload = NOISE_DIV1;
            RATE_DIV64: nreload = NOISE_DIV2;
            default:    nreload = (period_reg[NUM_TONES-1] == '0) ? TONE_W'(1)
                                                              : period_reg[NUM_TONES-1];
        endcase
        nfb = nctl_reg[2] ? (nshift_reg[0] ^ nshift_reg[3]) : nshift_reg[0];

        ncount_next = ncount_reg;
        nflip_next  = nflip_reg;
        nshift_next = nshift_reg;
        if (wr && !wr_vol && wr_ch == CH_NOISE)
        begin
            nshift_next = NOISE_SEED;
        end
        else if (tick)
        begin
            if (ncount_reg == '0)
            begin
                ncount_next = nreload - TONE_W'(1);
                nflip_next  = ~nflip_reg;
                if (!nflip_reg)
                begin
                    nshift_next = {nfb, nshift_reg[SHIFT_W-1:1]};
                end
            end
            else
            begin
                ncount_next = ncount_reg - TONE_W'(1);
            end
        end
    end

    // mixer, divide by four toward zero
    always_comb
    begin
        mix = '0;
        for (int i = 0; i < NUM_TONES; i++)
        begin
            if (tone_level[i])
            begin
                mix = mix + $signed({3'b000, vol_amp(volume_reg[i])});
            end
            else
            begin
                mix = mix - $signed({3'b000, vol_amp(volume_reg[i])});
            end
        end
        if (nshift_next[0])
        begin
            mix = mix + $signed({3'b000, vol_amp(volume_reg[NUM_TONES])});
        end
        else
        begin
            mix = mix - $signed({3'b000, vol_amp(volume_reg[NUM_TONES])});
        end
        mix_adj = mix[MIX_W-1] ? (mix + MIX_W'(3)) : mix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            latch_ch_reg  <= '0;
            latch_vol_reg <= 1'b0;
            nctl_reg      <= '0;
            ncount_reg    <= '0;
            nflip_reg     <= 1'b0;
            nshift_reg    <= NOISE_SEED;
            for (int i = 0; i < NUM_TONES; i++)
            begin
                period_reg[i] <= '0;
            end
            for (int i = 0; i <= NUM_TONES; i++)
            begin
                volume_reg[i] <= VOL_SILENT;
            end
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (tick)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            latch_ch_reg  <= latch_ch_next;
            latch_vol_reg <= latch_vol_next;
            nctl_reg      <= nctl_next;
            ncount_reg    <= ncount_next;
            nflip_reg     <= nflip_next;
            nshift_reg    <= nshift_next;
            for (int i = 0; i < NUM_TONES; i++)
            begin
                period_reg[i] <= period_next[i];
            end
            for (int i = 0; i <= NUM_TONES; i++)
            begin
                volume_reg[i] <= volume_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_action_reg <= s_axis_tuser;
            in_byte_reg   <= s_axis_tdata;
        end
        if (tick)
        begin
            out_data_reg <= mix_adj[MIX_W-1:2];
        end
    end

    // noise shifter never locks up at zero
    a_shift_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        nshift_reg != '0)
        else $error("noise shifter reached zero");

    // a tick always leaves a sample waiting
    a_tick_out: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> m_axis_tvalid)
        else $error("tick gave no sample");

    // a write never disturbs a waiting sample
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && out_valid_reg && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("write disturbed pending sample");

endmodule

// ===== verif/stng_sample_checker.sv =====
// checker for the sound generator: watches both streams, predicts each sample and compares
`timescale 1ns / 1ps

module stng_sample_checker
    import stng_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // write_byte
    input  logic                s_axis_tuser,   // action
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [SAMPLE_W-1:0] m_axis_tdata,   // sample_out
    output int                  fail_count,
    output int                  outstanding,
    output int                  samples_checked
);

    localparam int AMP_LUT [16] = '{
        32767, 26028, 20675, 16422, 13045, 10362, 8231, 6568,
        5193,  4125,  3277,  2603,  2067,  1642,  1304, 0
    };

    logic [TONE_W-1:0]   tone_per [3];
    logic [TONE_W-1:0]   tone_cnt [3];
    logic                tone_lvl [3];
    logic [VOL_W-1:0]    atten [4];
    logic [NCTL_W-1:0]   noise_ctl;
    logic [TONE_W-1:0]   noise_cnt;
    logic                noise_flip;
    logic [SHIFT_W-1:0]  lfsr;
    logic [1:0]          sel_ch;
    logic                sel_vol;

    logic [SAMPLE_W-1:0] sample_q [$];

    task automatic clear_state();
        for (int i = 0; i < 3; i++)
        begin
            tone_per[i] = '0;
            tone_cnt[i] = '0;
            tone_lvl[i] = 1'b1;
        end
        for (int i = 0; i < 4; i++)
            atten[i] = VOL_SILENT;
        noise_ctl  = '0;
        noise_cnt  = '0;
        noise_flip = 1'b0;
        lfsr       = NOISE_SEED;
        sel_ch     = '0;
        sel_vol    = 1'b0;
    endtask

    task automatic bus_write(input logic [7:0] b);
        logic [1:0] ch;
        logic [5:0] d;
        if (b[7])
        begin
            ch      = b[6:5];
            sel_ch  = ch;
            sel_vol = b[4];
            d       = {2'b00, b[3:0]};
        end
        else
        begin
            ch = sel_ch;
            d  = b[5:0];
        end
        if (sel_vol)
            atten[ch] = d[3:0];
        else if (ch == CH_NOISE)
        begin
            noise_ctl = d[2:0];
            lfsr      = NOISE_SEED;
        end
        else if (b[7])
            tone_per[ch][3:0] = d[3:0];
        else
            tone_per[ch][9:4] = d;
    endtask

    task automatic tick_sample(output logic [SAMPLE_W-1:0] smp);
        logic [TONE_W-1:0] reload;
        logic              fb;
        int                mix;
        int                amp;
        for (int i = 0; i < 3; i++)
        begin
            if (tone_per[i] <= 1)
                tone_lvl[i] = 1'b1;
            else
            begin
                if (tone_cnt[i] == 0)
                begin
                    tone_cnt[i] = tone_per[i];
                    tone_lvl[i] = ~tone_lvl[i];
                end
                tone_cnt[i] = tone_cnt[i] - 1'b1;
            end
        end
        case (noise_rate_t'(noise_ctl[1:0]))
            RATE_DIV16: reload = NOISE_DIV0;
            RATE_DIV32: reload = NOISE_DIV1;
            RATE_DIV64: reload = NOISE_DIV2;
            default:    reload = (tone_per[2] != 0) ? tone_per[2] : TONE_W'(1);
        endcase
        if (noise_cnt == 0)
        begin
            noise_cnt  = reload;
            noise_flip = ~noise_flip;
            if (noise_flip)
            begin
                fb   = noise_ctl[2] ? (lfsr[0] ^ lfsr[3]) : lfsr[0];
                lfsr = {fb, lfsr[SHIFT_W-1:1]};
            end
        end
        noise_cnt = noise_cnt - 1'b1;
        mix = 0;
        for (int i = 0; i < 3; i++)
        begin
            amp = AMP_LUT[atten[i]];
            mix += tone_lvl[i] ? amp : -amp;
        end
        amp = AMP_LUT[atten[3]];
        mix += lfsr[0] ? amp : -amp;
        mix = mix / 4;
        smp = mix[SAMPLE_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [SAMPLE_W-1:0] smp;
        if (!rst_n)
        begin
            clear_state();
            sample_q.delete();
            fail_count      <= 0;
            outstanding     <= 0;
            samples_checked <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sample_q.size() == 0)
                begin
                    $error("sample_out with no expected value: actual %0d",
                           $signed(m_axis_tdata));
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    smp = sample_q.pop_front();
                    if (smp !== m_axis_tdata)
                    begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               $signed(smp), $signed(m_axis_tdata));
                        fail_count <= fail_count + 1;
                    end
                    samples_checked <= samples_checked + 1;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (action_t'(s_axis_tuser) == ACT_TICK)
                begin
                    tick_sample(smp);
                    sample_q.push_back(smp);
                end
                else
                    bus_write(s_axis_tdata);
            end
            outstanding <= sample_q.size();
        end
    end

endmodule

// ===== verif/tb_square_tone_noise_sound_generator.sv =====
// testbench top for the sound generator: clock, reset, stimulus, output pacing and verdict
`timescale 1ns / 1ps

module tb_square_tone_noise_sound_generator;
    import stng_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;    // write_byte
    logic                s_axis_tuser = 1'b0;  // action
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;         // sample_out

    int fail_count;
    int outstanding;
    int samples_checked;

    logic idle_en = 1'b1;
    logic rx_hold = 1'b0;
    int   gap_pct = 15;
    int   n_writes = 0;
    int   n_ticks = 0;

    square_tone_noise_sound_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    stng_sample_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .samples_checked (samples_checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(input action_t act, input logic [7:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (act == ACT_TICK)
            n_ticks++;
        else
            n_writes++;
        if (idle_en && $urandom_range(1, 100) <= gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic wr(input logic [7:0] b);
        send_item(ACT_WRITE, b);
    endtask

    task automatic tick();
        send_item(ACT_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (outstanding != 0 && guard < 5000);
    endtask

    // output side pacing
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (rx_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (150) @(posedge clk);
                rx_hold = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int         sent;
        int         r;
        int         hold_done;
        int         pause_done;
        logic [1:0] ch;
        logic [9:0] per;
        logic [3:0] vol;
        int         fails;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: silence, full scale, period edge cases, noise modes
        tick();
        wr(8'h90);
        tick();
        wr(8'hF0);
        tick();
        wr(8'hB0);
        wr(8'hD0);
        tick();
        wr(8'h81);
        wr(8'h00);
        tick();
        wr(8'hAF);
        wr(8'h3F);
        tick();
        wr(8'hC2);
        wr(8'h40);
        tick();
        tick();
        tick();
        wr(8'hE7);
        tick();
        wr(8'h7C);
        tick();
        wr(8'hFF);
        wr(8'h0E);
        tick();

        sent = 0;
        hold_done = 0;
        pause_done = 0;
        while (sent < 500)
        begin
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
            if (sent > 420)
                idle_en = 1'b0;
            if (!hold_done && sent > 200)
            begin
                // output held off while ticks keep coming
                rx_hold = 1'b1;
                repeat (40) tick();
                sent += 40;
                hold_done = 1;
            end
            else if (!pause_done && sent > 330)
            begin
                s_axis_tvalid <= 1'b0;
                drain();
                pause_done = 1;
            end
            r = $urandom_range(0, 99);
            ch = 2'($urandom_range(0, 2));
            if (r < 45)
            begin
                r = $urandom_range(1, 8);
                repeat (r) tick();
                sent += r;
            end
            else if (r < 60)
            begin
                per = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                  : 10'($urandom_range(0, 24));
                wr({1'b1, ch, 1'b0, per[3:0]});
                wr({1'b0, 1'($urandom_range(0, 1)), per[9:4]});
                sent += 2;
            end
            else if (r < 72)
            begin
                ch = 2'($urandom_range(0, 3));
                vol = 4'($urandom_range(0, 15));
                wr({1'b1, ch, 1'b1, vol});
                sent++;
                if ($urandom_range(0, 1))
                begin
                    wr({1'b0, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))});
                    sent++;
                end
            end
            else if (r < 85)
            begin
                wr({1'b1, CH_NOISE, 1'b0, 4'($urandom_range(0, 15))});
                sent++;
                if ($urandom_range(0, 2) == 0)
                begin
                    wr({1'b0, 7'($urandom_range(0, 127))});
                    sent++;
                end
            end
            else
            begin
                wr(8'($urandom_range(0, 255)));
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        drain();
        repeat (8) @(posedge clk);
        fails = fail_count;
        if (outstanding != 0)
        begin
            $error("%0d expected samples never arrived", outstanding);
            fails++;
        end
        $display("Covered %0d bus writes and %0d ticks (%0d samples compared),",
                 n_writes, n_ticks, samples_checked);
        $display("with random idling, a long output hold-off and a full drain pause.");
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== square_tone_noise_sound_generator.f =====
rtl/stng_pkg.sv
rtl/stng_tone.sv
rtl/square_tone_noise_sound_generator.sv
verif/stng_sample_checker.sv
verif/tb_square_tone_noise_sound_generator.sv
